>>> design/vdht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdht_pkg
// Shared sizes and hash constants for the vertex deduplication hash table.
// ----------------------------------------------------------------------------
package vdht_pkg;
    localparam int CAPACITY   = 4096;
    localparam int BUCKETS    = 4096;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int LINK_W     = IDX_W + 1;
    localparam int BKT_W      = $clog2(BUCKETS);
    localparam int SRC_W      = 20;
    localparam int WORD_W     = 32;
    localparam int KEY_W      = 8 * WORD_W;
    localparam logic [LINK_W-1:0] NO_ENTRY = LINK_W'(CAPACITY);
    localparam logic [WORD_W-1:0] H_PX = 32'd10;
    localparam logic [WORD_W-1:0] H_PY = 32'd100;
    localparam logic [WORD_W-1:0] H_PZ = 32'd112;
    localparam logic [WORD_W-1:0] H_TS = 32'd123;
    localparam logic [WORD_W-1:0] H_TT = 32'd42;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HASH  = 7'b0000010,
        ST_HEAD  = 7'b0000100,
        ST_READ  = 7'b0001000,
        ST_CMP   = 7'b0010000,
        ST_CLEAR = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;
endpackage
`default_nettype wire

>>> design/vertex_dedup_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// When its bucket is empty, an item's result is registered after the bucket head
// read, chain head load and walk check; each chain entry visited adds an entry
// memory read and a compare.
// One item is in flight at a time; the next item is accepted in the cycle after
// the result is taken.
// After reset the bucket head memory is cleared, one bucket a cycle, and no item
// is accepted until all BUCKETS (4096) buckets are cleared.
// ----------------------------------------------------------------------------
// vertex_dedup_hash_table
// Hashes vertex attributes to a bucket, walks the chain in entry memory and
// returns the existing dense index or appends a new entry, or flags table_full.
// ----------------------------------------------------------------------------
module vertex_dedup_hash_table (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [19:0] source_vertex,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic [31:0] norm_x,
    input  wire logic [31:0] norm_y,
    input  wire logic [31:0] norm_z,
    input  wire logic [31:0] tex_s,
    input  wire logic [31:0] tex_t,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [11:0]      vertex_index,
    output logic [19:0]      first_source,
    output logic             was_new,
    output logic             table_full
);
    localparam int IW = vdht_pkg::IDX_W;
    localparam int LW = vdht_pkg::LINK_W;
    localparam int BW = vdht_pkg::BKT_W;
    localparam int KW = vdht_pkg::KEY_W;

    logic [KW-1:0]  key_mem  [vdht_pkg::CAPACITY];
    logic [19:0]    src_mem  [vdht_pkg::CAPACITY];
    logic [LW-1:0]  next_mem [vdht_pkg::CAPACITY];
    logic [LW-1:0]  head_mem [vdht_pkg::BUCKETS];

    vdht_pkg::state_t state_reg, state_next;
    logic [KW-1:0]  key_reg;
    logic [19:0]    src_reg;
    logic [31:0]    hash_reg;
    logic [BW-1:0]  bkt_reg;
    logic [LW-1:0]  cur_reg, cur_next;
    logic [LW-1:0]  head_reg;
    logic [LW-1:0]  count_reg;
    logic [LW-1:0]  steps_reg, steps_next;
    logic [BW-1:0]  clr_reg;
    logic [KW-1:0]  key_rd;
    logic [19:0]    src_rd;
    logic [LW-1:0]  next_rd;
    logic [LW-1:0]  head_rd;
    logic           head_we, entry_we;
    logic [LW-1:0]  head_wd;
    logic [BW-1:0]  head_wa;
    logic [11:0]    res_idx_next;
    logic [19:0]    res_src_next;
    logic           res_new_next, res_full_next, res_load;
    logic           walk_ok;

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            key_mem[count_reg[IW-1:0]]  <= key_reg;
            src_mem[count_reg[IW-1:0]]  <= src_reg;
            next_mem[count_reg[IW-1:0]] <= head_reg;
        end
        key_rd  <= key_mem[cur_reg[IW-1:0]];
        src_rd  <= src_mem[cur_reg[IW-1:0]];
        next_rd <= next_mem[cur_reg[IW-1:0]];
    end

    // The head is read straight from the hash register so that it is ready
    // when the walk starts.
    always_ff @(posedge clk)
    begin
        if (head_we)
            head_mem[head_wa] <= head_wd;
        head_rd <= head_mem[hash_reg[BW-1:0]];
    end

    assign in_ready = (state_reg == vdht_pkg::ST_IDLE);
    assign walk_ok  = (cur_reg < count_reg) && (steps_reg < count_reg);

    always_comb
    begin
        state_next    = state_reg;
        cur_next      = cur_reg;
        steps_next    = steps_reg;
        head_we       = 1'b0;
        head_wa       = bkt_reg;
        head_wd       = count_reg;
        entry_we      = 1'b0;
        res_load      = 1'b0;
        res_idx_next  = '0;
        res_src_next  = '0;
        res_new_next  = 1'b0;
        res_full_next = 1'b0;
        unique case (state_reg)
            vdht_pkg::ST_CLEAR:
            begin
                head_we = 1'b1;
                head_wa = clr_reg;
                head_wd = vdht_pkg::NO_ENTRY;
                if (clr_reg == BW'(vdht_pkg::BUCKETS - 1))
                    state_next = vdht_pkg::ST_IDLE;
            end
            vdht_pkg::ST_IDLE:
                if (in_valid)
                    state_next = vdht_pkg::ST_HASH;
            vdht_pkg::ST_HASH:
                state_next = vdht_pkg::ST_HEAD;
            vdht_pkg::ST_HEAD:
            begin
                cur_next   = head_rd;
                steps_next = '0;
                state_next = vdht_pkg::ST_READ;
            end
            vdht_pkg::ST_READ:
            begin
                if (walk_ok)
                    state_next = vdht_pkg::ST_CMP;
                else
                begin
                    res_load   = 1'b1;
                    state_next = vdht_pkg::ST_OUT;
                    if (count_reg >= LW'(vdht_pkg::CAPACITY))
                        res_full_next = 1'b1;
                    else
                    begin
                        entry_we     = 1'b1;
                        head_we      = 1'b1;
                        res_idx_next = count_reg[11:0];
                        res_src_next = src_reg;
                        res_new_next = 1'b1;
                    end
                end
            end
            vdht_pkg::ST_CMP:
            begin
                if (key_rd == key_reg)
                begin
                    res_load     = 1'b1;
                    res_idx_next = cur_reg[11:0];
                    res_src_next = src_rd;
                    state_next   = vdht_pkg::ST_OUT;
                end
                else
                begin
                    cur_next   = next_rd;
                    steps_next = steps_reg + 1'b1;
                    state_next = vdht_pkg::ST_READ;
                end
            end
            vdht_pkg::ST_OUT:
                if (out_ready)
                    state_next = vdht_pkg::ST_IDLE;
            default:
                state_next = vdht_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vdht_pkg::ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == vdht_pkg::ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (entry_we)
                count_reg <= count_reg + 1'b1;
            if (res_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        steps_reg <= steps_next;
        if (in_ready && in_valid)
        begin
            key_reg <= {tex_t, tex_s, norm_z, norm_y, norm_x, pos_z, pos_y, pos_x};
            src_reg <= source_vertex;
            hash_reg <= vdht_pkg::H_PX * pos_x + vdht_pkg::H_PY * pos_y
                      + vdht_pkg::H_PZ * pos_z + vdht_pkg::H_TS * tex_s
                      + vdht_pkg::H_TT * tex_t;
        end
        if (state_reg == vdht_pkg::ST_HASH)
            bkt_reg <= hash_reg[BW-1:0];
        if (state_reg == vdht_pkg::ST_HEAD)
            head_reg <= head_rd;
        if (res_load)
        begin
            vertex_index <= res_idx_next;
            first_source <= res_src_next;
            was_new      <= res_new_next;
            table_full   <= res_full_next;
        end
    end
endmodule
`default_nettype wire
